>>> src/assert_macros.svh
// Assertion macros used by the assertion module in src/pfmp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/pfmp_pkg.sv
package pfmp_pkg;

  localparam int MAX_PAIRS_DEF     = 2048;
  localparam int CORDIC_STAGES_DEF = 24;

  localparam int WORD_W    = 32;
  localparam int BIN_W     = 12;
  localparam int PHASE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_ENABLE = 2'd1;

  localparam int IN_SHIFT = 24;
  localparam int XY_W     = 58;
  localparam int Z_W      = 33;
  localparam int ATAN_LEN = 40;

  localparam int SQ_W       = 2 * WORD_W;
  localparam int ROOT_W     = WORD_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_CELLS = ROOT_W;

  localparam logic signed [Z_W-1:0]     Z_HALF_PI     = 33'sh040000000;
  localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI = 16'sd16384;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
  } sqrt_t;

  // Rotation angles round(atan(2^-i) * 2^31 / pi).
  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:  val = 33'sh020000000;
      1:  val = 33'sh012E4051E;
      2:  val = 33'sh009FB385B;
      3:  val = 33'sh0051111D4;
      4:  val = 33'sh0028B0D43;
      5:  val = 33'sh00145D7E1;
      6:  val = 33'sh000A2F61E;
      7:  val = 33'sh000517C55;
      8:  val = 33'sh00028BE53;
      9:  val = 33'sh000145F2F;
      10: val = 33'sh0000A2F98;
      11: val = 33'sh0000517CC;
      12: val = 33'sh000028BE6;
      13: val = 33'sh0000145F3;
      14: val = 33'sh00000A2FA;
      15: val = 33'sh00000517D;
      16: val = 33'sh0000028BE;
      17: val = 33'sh00000145F;
      18: val = 33'sh000000A30;
      19: val = 33'sh000000518;
      20: val = 33'sh00000028C;
      21: val = 33'sh000000146;
      22: val = 33'sh0000000A3;
      23: val = 33'sh000000051;
      24: val = 33'sh000000029;
      25: val = 33'sh000000014;
      26: val = 33'sh00000000A;
      27: val = 33'sh000000005;
      28: val = 33'sh000000003;
      29: val = 33'sh000000001;
      30: val = 33'sh000000001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> src/pfmp_ifs.sv
interface pfmp_in_if;
  import pfmp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word_even;
  logic signed [WORD_W-1:0] word_odd;
  logic                     frame_end;

  modport source (output valid, word_even, word_odd, frame_end, input ready);
  modport sink (input valid, word_even, word_odd, frame_end, output ready);
endinterface

interface pfmp_out_if;
  import pfmp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [BIN_W-1:0]          bin_index;
  logic [WORD_W-1:0]         magnitude_out;
  logic signed [PHASE_W-1:0] phase_out;
  logic                      mag_valid;
  logic                      phase_valid;
  logic                      frame_last;

  modport source (output valid, bin_index, magnitude_out, phase_out, mag_valid,
                  phase_valid, frame_last, input ready);
  modport sink (input valid, bin_index, magnitude_out, phase_out, mag_valid,
                phase_valid, frame_last, output ready);
endinterface

>>> src/packed_fft_magnitude_phase.sv
// Packed real-FFT frame to per-bin magnitude and phase.
// Requests arrive on in_ch, one word pair per request: the first pair of a
// frame carries DC and Nyquist, every later pair the real and imaginary part
// of one bin. frame_end marks the last pair; a frame also ends at pair
// MAX_PAIRS-1. Results leave on out_ch, one per bin, and the held Nyquist
// value follows the last pair's result with frame_last set.
// The cfg_ port sets mag_enable and phase_enable; write it only while idle.
// One request is worked on at a time. Its data runs through a chain of
// CORDIC_STAGES rotation cells and a chain of 32 square-root cells, one bit
// per cell, behind the squaring and summing registers; the longer chain sets
// the time. The result is then captured in a result register and loaded into
// the output register, and the next request can be taken after that, or after
// the held Nyquist value is loaded as well when the pair ends a frame.
// The output register holds a result while out_ch.ready is low, and the next
// request is processed meanwhile; it waits only for the register to free.
// Reset clears the pair count and the held Nyquist word, sets mag_enable to
// 1 and phase_enable to 0, and empties the output.
module packed_fft_magnitude_phase #(
  parameter int MAX_PAIRS     = pfmp_pkg::MAX_PAIRS_DEF,
  parameter int CORDIC_STAGES = pfmp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfmp_in_if.sink                        in_ch,
  pfmp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pfmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfmp_pkg::CFG_DAT_W-1:0] cfg_data
);
  import pfmp_pkg::*;

  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int CHAIN_LAT = (CORDIC_STAGES > SQRT_CELLS + 2) ? CORDIC_STAGES
                                                              : SQRT_CELLS + 2;
  localparam int RUN_W     = $clog2(CHAIN_LAT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_LOAD1 = 2'd2;
  localparam logic [1:0] ST_LOAD2 = 2'd3;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [RUN_W-1:0]         run_cnt_r;
  logic [CNT_W-1:0]         pair_cnt_r;
  logic [CNT_W-1:0]         pair_cnt_nxt;
  logic [WORD_W-1:0]        hold_r;
  logic                     mag_en_r;
  logic                     ph_en_r;

  logic signed [WORD_W-1:0] ev_r;
  logic signed [WORD_W-1:0] od_r;
  logic                     end_r;
  logic                     dc_r;
  logic [CNT_W-1:0]         bin_r;

  logic [SQ_W-1:0]          prod_re_r;
  logic [SQ_W-1:0]          prod_im_r;
  logic [SQ_W-1:0]          sq_r;
  logic [WORD_W-1:0]        res_mag_r;
  logic signed [PHASE_W-1:0] res_ph_r;

  logic                     out_valid_r;
  logic [BIN_W-1:0]         out_bin_r;
  logic [WORD_W-1:0]        out_mag_r;
  logic signed [PHASE_W-1:0] out_ph_r;
  logic                     out_mag_vld_r;
  logic                     out_ph_vld_r;
  logic                     out_last_r;

  logic                     in_fire;
  logic                     last_pair;
  logic                     run_done;
  logic                     out_free;
  logic                     load1;
  logic                     load2;
  logic                     m_on;
  logic [WORD_W-1:0]        abs_ev;
  logic [WORD_W-1:0]        abs_od;
  logic [WORD_W-1:0]        abs_hold;
  logic [31:0]              bin_ext;
  logic [31:0]              bin_inc;

  logic signed [Z_W-1:0]    z_fin;
  logic signed [Z_W-1:0]    z_cl;
  logic [30:0]              z_rnd;
  logic signed [PHASE_W-1:0] ph_abs;
  logic signed [PHASE_W-1:0] ph_calc;
  logic [WORD_W-1:0]        mag_calc;

  cordic_t                  cstage [CORDIC_STAGES+1];
  sqrt_t                    sstage [SQRT_CELLS+1];

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign last_pair = in_ch.frame_end || (pair_cnt_r >= CNT_W'(MAX_PAIRS - 1));
  assign run_done  = (state_r == ST_RUN) && (run_cnt_r == RUN_W'(CHAIN_LAT));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load1     = (state_r == ST_LOAD1) && out_free;
  assign load2     = (state_r == ST_LOAD2) && out_free;
  assign m_on      = mag_en_r || !ph_en_r;

  assign abs_ev   = ev_r[WORD_W-1] ? (~ev_r + 1'b1) : ev_r;
  assign abs_od   = od_r[WORD_W-1] ? (~od_r + 1'b1) : od_r;
  assign abs_hold = hold_r[WORD_W-1] ? (~hold_r + 1'b1) : hold_r;
  assign bin_ext  = 32'(bin_r);
  assign bin_inc  = bin_ext + 32'd1;

  always_comb begin
    state_nxt    = state_r;
    pair_cnt_nxt = pair_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt    = ST_RUN;
          pair_cnt_nxt = last_pair ? '0 : pair_cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = ST_LOAD1;
        end
      end
      ST_LOAD1: begin
        if (load1) begin
          state_nxt = end_r ? ST_LOAD2 : ST_IDLE;
        end
      end
      ST_LOAD2: begin
        if (load2) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_cnt_r   <= '0;
      pair_cnt_r  <= '0;
      hold_r      <= '0;
      mag_en_r    <= 1'b1;
      ph_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pair_cnt_r <= pair_cnt_nxt;
      if (in_fire) begin
        run_cnt_r <= '0;
      end else if (state_r == ST_RUN) begin
        run_cnt_r <= run_cnt_r + 1'b1;
      end
      if (in_fire && (pair_cnt_r == '0)) begin
        hold_r <= in_ch.word_odd;
      end
      if (cfg_we && (cfg_index == REG_MAG_ENABLE)) begin
        mag_en_r <= cfg_data[0];
      end
      if (cfg_we && (cfg_index == REG_PHASE_ENABLE)) begin
        ph_en_r <= cfg_data[0];
      end
      if (load1 || load2) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r  <= in_ch.word_even;
      od_r  <= in_ch.word_odd;
      end_r <= last_pair;
      dc_r  <= (pair_cnt_r == '0);
      bin_r <= pair_cnt_r;
    end
    prod_re_r <= abs_ev * abs_ev;
    prod_im_r <= abs_od * abs_od;
    sq_r      <= prod_re_r + prod_im_r;
    if (run_done) begin
      res_mag_r <= mag_calc;
      res_ph_r  <= ph_calc;
    end
    if (load1) begin
      out_bin_r     <= bin_ext[BIN_W-1:0];
      out_mag_r     <= m_on ? res_mag_r : '0;
      out_ph_r      <= ph_en_r ? res_ph_r : '0;
      out_mag_vld_r <= m_on;
      out_ph_vld_r  <= ph_en_r;
      out_last_r    <= 1'b0;
    end else if (load2) begin
      out_bin_r     <= bin_inc[BIN_W-1:0];
      out_mag_r     <= m_on ? abs_hold : '0;
      out_ph_r      <= '0;
      out_mag_vld_r <= m_on;
      out_ph_vld_r  <= ph_en_r;
      out_last_r    <= 1'b1;
    end
  end

  assign cstage[0].x = XY_W'({abs_ev, {IN_SHIFT{1'b0}}});
  assign cstage[0].y = XY_W'({abs_od, {IN_SHIFT{1'b0}}});
  assign cstage[0].z = '0;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    pfmp_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .cell_in  (cstage[g]),
      .cell_out (cstage[g+1])
    );
  end

  assign sstage[0].rem  = '0;
  assign sstage[0].root = '0;
  assign sstage[0].rad  = sq_r;

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    pfmp_sqrt_cell u_cell (
      .clk      (clk),
      .cell_in  (sstage[g]),
      .cell_out (sstage[g+1])
    );
  end

  assign z_fin = cstage[CORDIC_STAGES].z;

  always_comb begin
    if (z_fin[Z_W-1]) begin
      z_cl = '0;
    end else if (z_fin > Z_HALF_PI) begin
      z_cl = Z_HALF_PI;
    end else begin
      z_cl = z_fin;
    end
    z_rnd  = z_cl[30:0] + 31'd32768;
    ph_abs = PHASE_W'({1'b0, z_rnd[30:16]});
    if (dc_r || (od_r == '0)) begin
      ph_calc = '0;
    end else if (ev_r == '0) begin
      ph_calc = od_r[WORD_W-1] ? -PHASE_HALF_PI : PHASE_HALF_PI;
    end else if (ev_r[WORD_W-1] != od_r[WORD_W-1]) begin
      ph_calc = -ph_abs;
    end else begin
      ph_calc = ph_abs;
    end
    mag_calc = dc_r ? abs_ev : sstage[SQRT_CELLS].root;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.bin_index     = out_bin_r;
  assign out_ch.magnitude_out = out_mag_r;
  assign out_ch.phase_out     = out_ph_r;
  assign out_ch.mag_valid     = out_mag_vld_r;
  assign out_ch.phase_valid   = out_ph_vld_r;
  assign out_ch.frame_last    = out_last_r;
endmodule

>>> src/pfmp_cordic_cell.sv
module pfmp_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pfmp_pkg::cordic_t cell_in,
  output pfmp_pkg::cordic_t cell_out
);
  import pfmp_pkg::*;

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  z_in;
  logic signed [Z_W-1:0]  ang;
  cordic_t                cell_r;
  cordic_t                cell_nxt;

  assign x_in = cell_in.x;
  assign y_in = cell_in.y;
  assign z_in = cell_in.z;
  assign dx   = y_in >>> IDX;
  assign dy   = x_in >>> IDX;
  assign ang  = atan_entry(IDX);

  always_comb begin
    if (!y_in[XY_W-1]) begin
      cell_nxt.x = x_in + dx;
      cell_nxt.y = y_in - dy;
      cell_nxt.z = z_in + ang;
    end else begin
      cell_nxt.x = x_in - dx;
      cell_nxt.y = y_in + dy;
      cell_nxt.z = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;
endmodule

>>> src/pfmp_sqrt_cell.sv
module pfmp_sqrt_cell (
  input  logic            clk,
  input  pfmp_pkg::sqrt_t cell_in,
  output pfmp_pkg::sqrt_t cell_out
);
  import pfmp_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  sqrt_t            cell_r;
  sqrt_t            cell_nxt;

  assign rem_sh = {cell_in.rem[REM_W-3:0], cell_in.rad[SQ_W-1 -: 2]};
  assign trial  = {cell_in.root, 2'b01};

  always_comb begin
    cell_nxt.rad = {cell_in.rad[SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;
endmodule

>>> src/pfmp_checker.sv
`include "assert_macros.svh"

module pfmp_assertions (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pfmp_pkg::BIN_W-1:0]       out_bin_index,
  input logic [pfmp_pkg::WORD_W-1:0]      out_magnitude_out,
  input logic signed [pfmp_pkg::PHASE_W-1:0] out_phase_out,
  input logic                             out_phase_valid,
  input logic                             out_frame_last
);
  import pfmp_pkg::*;

  logic [BIN_W+WORD_W+PHASE_W-1:0] out_payload;

  assign out_payload = {out_bin_index, out_magnitude_out, out_phase_out};

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  `ASSERT_IMPLY(a_last_not_dc, clk, rst_n, out_valid && out_frame_last, out_bin_index != '0)

  `ASSERT_IMPLY(a_phase_off_zero, clk, rst_n, out_valid && !out_phase_valid, out_phase_out == '0)
endmodule

bind packed_fft_magnitude_phase pfmp_assertions u_pfmp_assertions (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_bin_index     (out_ch.bin_index),
  .out_magnitude_out (out_ch.magnitude_out),
  .out_phase_out     (out_ch.phase_out),
  .out_phase_valid   (out_ch.phase_valid),
  .out_frame_last    (out_ch.frame_last)
);

>>> test/pfmp_checker.sv
module pfmp_checker #(
  parameter int MAX_PAIRS     = pfmp_pkg::MAX_PAIRS_DEF,
  parameter int CORDIC_STAGES = pfmp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfmp_in_if                             in_ch,
  pfmp_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [pfmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfmp_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             n_fail,
  output int                             n_pending,
  output int                             n_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfmp_pkg::*;

  localparam real PI         = 3.14159265358979323846;
  localparam int  PRINT_CAP  = 100;
  localparam int  ANGLE_DROP = 16;

  typedef struct packed {
    logic [BIN_W-1:0]          bin_index;
    logic [WORD_W-1:0]         magnitude;
    logic signed [PHASE_W-1:0] phase;
    logic                      mag_valid;
    logic                      phase_valid;
    logic                      frame_last;
  } bin_result_t;

  bin_result_t              pending_bins[$];
  bin_result_t              oldest;
  longint                   rot_angle[ATAN_LEN];
  logic [BIN_W-1:0]         pair_idx;
  logic signed [WORD_W-1:0] held_nyquist;
  logic                     mag_on;
  logic                     phase_on;

  initial begin
    int i;
    for (i = 0; i < ATAN_LEN; i++) begin
      rot_angle[i] = longint'($rtoi($atan(1.0 / (2.0 ** i)) * (2.0 ** 31) / PI + 0.5));
    end
  end

  function automatic longint abs_word(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [WORD_W-1:0] bin_magnitude(input longint re, input longint im);
    logic [63:0] rad;
    logic [63:0] root;
    logic [63:0] probe;
    rad   = abs_word(re) * abs_word(re) + abs_word(im) * abs_word(im);
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[WORD_W-1:0];
  endfunction

  function automatic logic signed [PHASE_W-1:0] bin_phase(input longint re, input longint im);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint ang;
    int     i;
    if (im == 0) return '0;
    if (re == 0) return (im > 0) ? PHASE_HALF_PI : -PHASE_HALF_PI;
    x = abs_word(re) <<< IN_SHIFT;
    y = abs_word(im) <<< IN_SHIFT;
    z = 0;
    for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + rot_angle[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - rot_angle[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(Z_HALF_PI)) z = longint'(Z_HALF_PI);
    ang = (z + (longint'(1) <<< (ANGLE_DROP - 1))) >>> ANGLE_DROP;
    if ((re < 0) != (im < 0)) ang = -ang;
    return ang[PHASE_W-1:0];
  endfunction

  function automatic void add_bin(input logic [BIN_W-1:0] bin, input logic [WORD_W-1:0] mag,
                                  input logic signed [PHASE_W-1:0] ph, input logic last);
    bin_result_t r;
    logic        m_on;
    m_on          = mag_on || !phase_on;
    r.bin_index   = bin;
    r.magnitude   = m_on ? mag : '0;
    r.phase       = phase_on ? ph : '0;
    r.mag_valid   = m_on;
    r.phase_valid = phase_on;
    r.frame_last  = last;
    pending_bins.push_back(r);
  endfunction

  function automatic void predict_bins(input logic signed [WORD_W-1:0] ev,
                                       input logic signed [WORD_W-1:0] od, input logic fe);
    logic [BIN_W-1:0] k;
    logic             ends;
    longint           re;
    longint           im;
    longint           nq;
    k    = pair_idx;
    re   = longint'(ev);
    im   = longint'(od);
    ends = fe || (k >= MAX_PAIRS - 1);
    if (k == 0) begin
      held_nyquist = od;
      add_bin('0, WORD_W'(abs_word(re)), '0, 1'b0);
    end else begin
      add_bin(k, bin_magnitude(re, im), bin_phase(re, im), 1'b0);
    end
    if (ends) begin
      nq = longint'(held_nyquist);
      add_bin(k + 1'b1, WORD_W'(abs_word(nq)), '0, 1'b1);
      pair_idx = '0;
    end else begin
      pair_idx = k + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string field, input int bin, input longint got,
                                 input longint want);
    n_fail++;
    if (n_fail <= PRINT_CAP) begin
      $display("%0t ns: bin %0d %s got %0d, expected %0d", $time, bin, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_bins.delete();
      pair_idx     = '0;
      held_nyquist = '0;
      mag_on       = 1'b1;
      phase_on     = 1'b0;
      n_fail       = 0;
      n_checked    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAG_ENABLE:   mag_on = cfg_data[0];
          REG_PHASE_ENABLE: phase_on = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bins.size() == 0) begin
          report_mismatch("result with no request outstanding, valid",
                          int'(out_ch.bin_index), longint'(1), longint'(0));
        end else begin
          oldest = pending_bins.pop_front();
          n_checked++;
          if (out_ch.bin_index !== oldest.bin_index)
            report_mismatch("bin_index", int'(oldest.bin_index), longint'(out_ch.bin_index),
                            longint'(oldest.bin_index));
          if (out_ch.magnitude_out !== oldest.magnitude)
            report_mismatch("magnitude_out", int'(oldest.bin_index),
                            longint'(out_ch.magnitude_out), longint'(oldest.magnitude));
          if (out_ch.phase_out !== oldest.phase)
            report_mismatch("phase_out", int'(oldest.bin_index), longint'(out_ch.phase_out),
                            longint'(oldest.phase));
          if (out_ch.mag_valid !== oldest.mag_valid)
            report_mismatch("mag_valid", int'(oldest.bin_index), longint'(out_ch.mag_valid),
                            longint'(oldest.mag_valid));
          if (out_ch.phase_valid !== oldest.phase_valid)
            report_mismatch("phase_valid", int'(oldest.bin_index),
                            longint'(out_ch.phase_valid), longint'(oldest.phase_valid));
          if (out_ch.frame_last !== oldest.frame_last)
            report_mismatch("frame_last", int'(oldest.bin_index),
                            longint'(out_ch.frame_last), longint'(oldest.frame_last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_bins(in_ch.word_even, in_ch.word_odd, in_ch.frame_end);
      end
    end
    n_pending = pending_bins.size();
  end

endmodule

>>> test/tb_packed_fft_magnitude_phase.sv
module tb_packed_fft_magnitude_phase;
  timeunit 1ns;
  timeprecision 1ps;
  import pfmp_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 125;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum {RX_FREE, RX_COIN, RX_SLOW} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int                   n_fail;
  int                   n_pending;
  int                   n_checked;
  int                   cycles = 0;
  int                   n_sent;
  int                   burst_left;
  int                   rx_left;
  rx_mode_t             rx_mode;

  pfmp_in_if  in_ch ();
  pfmp_out_if out_ch ();

  packed_fft_magnitude_phase u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfmp_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles with %0d results outstanding", cycles, n_pending);
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE: out_ch.ready <= 1'b1;
      RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic pause(input int n);
    in_ch.valid     <= 1'b0;
    in_ch.word_even <= $urandom;
    in_ch.word_odd  <= $urandom;
    in_ch.frame_end <= 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk);
  endtask

  task automatic send_req(input logic signed [WORD_W-1:0] ev, input logic signed [WORD_W-1:0] od,
                          input logic fe);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      pause($urandom_range(1, 45));
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.word_even <= ev;
    in_ch.word_odd  <= od;
    in_ch.frame_end <= fe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain();
    pause(1);
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic set_mode(input logic mag_on, input logic phase_on);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAG_ENABLE;
    cfg_data  <= mag_on;
    @(negedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_data  <= CFG_DAT_W'($urandom_range(0, 1));
    @(negedge clk);
    cfg_index <= REG_PHASE_ENABLE;
    cfg_data  <= phase_on;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return ($urandom_range(0, 1) != 0) ? 1 : -1;
      4, 5:    return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_frame(input int len, input logic marked);
    int k;
    for (k = 0; k < len; k++) begin
      send_req(pick_word(), pick_word(), marked && (k == len - 1));
    end
  endtask

  initial begin
    int s;
    int r;
    int phase_start;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.word_even = '0;
    in_ch.word_odd  = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    rx_mode         = RX_FREE;
    rx_left         = 0;
    burst_left      = 0;
    n_sent          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_mode(1'b1, 1'b1);
    send_req(WORD_MIN, WORD_MAX, 1'b0);
    send_req(WORD_MIN, WORD_MIN, 1'b0);
    send_req(WORD_MAX, WORD_MAX, 1'b0);
    send_req(WORD_MAX, WORD_MIN, 1'b0);
    send_req(0, 5, 1'b0);
    send_req(0, -7, 1'b0);
    send_req(9, 0, 1'b0);
    send_req(-9, 0, 1'b0);
    send_req(0, 0, 1'b0);
    send_req(-3, 4, 1'b0);
    send_req(3, -4, 1'b0);
    send_req(-5, -12, 1'b0);
    send_req(1, 1, 1'b0);
    send_req(WORD_MIN, 0, 1'b0);
    send_req(0, WORD_MIN, 1'b0);
    send_req(-1, WORD_MAX, 1'b1);
    send_req(-1, WORD_MIN, 1'b1);
    send_req(0, 0, 1'b1);
    send_req(5, -2, 1'b0);
    send_req(7, -24, 1'b1);

    for (s = 0; s < 4; s++) begin
      drain();
      case (s)
        0:       set_mode(1'b1, 1'b0);
        1:       set_mode(1'b0, 1'b1);
        2:       set_mode(1'b0, 1'b0);
        default: set_mode(1'b1, 1'b1);
      endcase
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r < 6) send_frame($urandom_range(1, 6), 1'b1);
        else if (r < 9) send_frame($urandom_range(7, 24), 1'b1);
        else send_frame($urandom_range(25, 80), 1'b1);
        if ($urandom_range(0, 11) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d requests and checked %0d results under all four enable settings",
             n_sent, n_checked);
    $display("frames ran from a single pair to eighty pairs, with extreme and zero words");
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/pfmp_pkg.sv
src/pfmp_ifs.sv
src/pfmp_cordic_cell.sv
src/pfmp_sqrt_cell.sv
src/packed_fft_magnitude_phase.sv
src/pfmp_checker.sv
test/pfmp_checker.sv
test/tb_packed_fft_magnitude_phase.sv
